>>> sv/tsm_pkg.sv
package tsm_pkg;

	// block constants
	localparam int unsigned SAMPLE_RATE = 48000;
	localparam int unsigned PHASE_BITS  = 32;

	// pulse runs at 2^17/(2048-p) Hz, wave at half that rate
	localparam int unsigned FREQ_LOG2   = 17;
	localparam int unsigned PERIOD_SPAN = 2048;
	localparam int unsigned PERIOD_W    = 11;
	localparam int unsigned SPAN_W      = PERIOD_W + 1;

	// bit-serial divider: floor(2^DIV_STEPS / d)
	localparam int unsigned DIV_STEPS = FREQ_LOG2 + PHASE_BITS;
	localparam int unsigned DIV_W     = $clog2(PERIOD_SPAN * SAMPLE_RATE + 1);
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam int unsigned QUOT_W    = PHASE_BITS + 1;

	// configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = PERIOD_W;

	localparam logic [CFG_IDX_W-1:0] REG_P1_DUTY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P1_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P1_VOLUME = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P2_DUTY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_P2_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_P2_VOLUME = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_W_PERIOD  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_W_LEVEL   = 3'd7;

	// wave RAM
	localparam int unsigned WAVE_DEPTH = 16;
	localparam int unsigned WAVE_AW    = $clog2(WAVE_DEPTH);

	// samples
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned MAG_W    = 15;

	// x/3 as (x * 21846) >> 16, exact for |x| below 2^15
	localparam int unsigned RECIP3       = 21846;
	localparam int unsigned RECIP3_SHIFT = 16;

	// phase fractions of a period in eighths for each duty code
	function automatic logic [3:0] duty_eighths(input logic [1:0] duty);
		logic [3:0] e;
		case (duty)
			2'd0:    e = 4'd1;
			2'd1:    e = 4'd2;
			2'd2:    e = 4'd4;
			default: e = 4'd6;
		endcase
		return e;
	endfunction

	// floor(v * 98301 / 150)
	function automatic logic [MAG_W-1:0] pulse_amp(input logic [3:0] v);
		logic [MAG_W-1:0] a;
		case (v)
			4'd0:    a = 15'd0;
			4'd1:    a = 15'd655;
			4'd2:    a = 15'd1310;
			4'd3:    a = 15'd1966;
			4'd4:    a = 15'd2621;
			4'd5:    a = 15'd3276;
			4'd6:    a = 15'd3932;
			4'd7:    a = 15'd4587;
			4'd8:    a = 15'd5242;
			4'd9:    a = 15'd5898;
			4'd10:   a = 15'd6553;
			4'd11:   a = 15'd7208;
			4'd12:   a = 15'd7864;
			4'd13:   a = 15'd8519;
			4'd14:   a = 15'd9174;
			default: a = 15'd9830;
		endcase
		return a;
	endfunction

	// floor((2k+1) * 98301 / (150*div)), div from level; mute gives 0
	function automatic logic [MAG_W-1:0] wave_mag(input logic [1:0] level,
	                                              input logic [2:0] k);
		logic [MAG_W-1:0] m;
		m = '0;
		case (level)
			2'd1: begin
				case (k)
					3'd0:    m = 15'd655;
					3'd1:    m = 15'd1966;
					3'd2:    m = 15'd3276;
					3'd3:    m = 15'd4587;
					3'd4:    m = 15'd5898;
					3'd5:    m = 15'd7208;
					3'd6:    m = 15'd8519;
					default: m = 15'd9830;
				endcase
			end
			2'd2: begin
				case (k)
					3'd0:    m = 15'd327;
					3'd1:    m = 15'd983;
					3'd2:    m = 15'd1638;
					3'd3:    m = 15'd2293;
					3'd4:    m = 15'd2949;
					3'd5:    m = 15'd3604;
					3'd6:    m = 15'd4259;
					default: m = 15'd4915;
				endcase
			end
			2'd3: begin
				case (k)
					3'd0:    m = 15'd163;
					3'd1:    m = 15'd491;
					3'd2:    m = 15'd819;
					3'd3:    m = 15'd1146;
					3'd4:    m = 15'd1474;
					3'd5:    m = 15'd1802;
					3'd6:    m = 15'd2129;
					default: m = 15'd2457;
				endcase
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> sv/three_channel_tone_synth_mixer_top.sv
// Two pulse channels and one wave-table channel, mixed to one signed 16-bit
// sample per sample request (req_type 0). A write request (req_type 1) stores
// wave_data at wave_addr in the 16-byte wave RAM and returns no item. For a
// sample item the sequencer first forms the divisors and then starts the
// dividers. Then three bit-serial restoring dividers, running side by side,
// work out the phase increments floor(2^49 / ((2048-period)*SAMPLE_RATE)) at
// one quotient bit per cycle over PHASE_BITS+17 steps. Phase update, RAM
// read, channel evaluation and the divide-by-three follow in turn, in states
// S_DIV, S_RD, S_EVAL and S_FIN. The block returns to idle as the result is
// raised and takes no new request before then. A result still unread when the
// next one is ready holds the block in its final state. The wave channel's
// increment is the pulse-form quotient halved. The wave RAM is held in
// flip-flops that reset clears at once, so no clearing pass is needed.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
module three_channel_tone_synth_mixer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [tsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsm_pkg::CFG_W-1:0]           cfg_data,
	// request items
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [3:0]                          wave_addr,
	input  logic [7:0]                          wave_data,
	// result items
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  mixed_sample
);
	import tsm_pkg::*;

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_EVAL  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [1:0]          p1_duty_q;
	logic [PERIOD_W-1:0] p1_period_q;
	logic [3:0]          p1_vol_q;
	logic [1:0]          p2_duty_q;
	logic [PERIOD_W-1:0] p2_period_q;
	logic [3:0]          p2_vol_q;
	logic [PERIOD_W-1:0] w_period_q;
	logic [1:0]          w_level_q;

	// channel phases
	logic [PHASE_BITS-1:0] p1_phase_q;
	logic [PHASE_BITS-1:0] p2_phase_q;
	logic [PHASE_BITS-1:0] w_phase_q;

	// divisors, registered after the constant multiply
	logic [DIV_W-1:0] d_p1_s1;
	logic [DIV_W-1:0] d_p2_s1;
	logic [DIV_W-1:0] d_w_s1;

	logic              div_start;
	logic              p1_done, p2_done, w_done;
	logic [QUOT_W-1:0] p1_quot, p2_quot, w_quot;

	logic signed [SAMPLE_W-1:0] sum_q;
	logic signed [SAMPLE_W-1:0] out_q;
	logic                       out_valid_q;

	logic in_fire;
	logic ram_we;
	logic fin_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign ram_we    = in_fire && req_type;
	assign div_start = (state_q == S_START);
	// result slot free in the final state
	assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// config decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_duty_q   <= '0;
			p1_period_q <= '0;
			p1_vol_q    <= '0;
			p2_duty_q   <= '0;
			p2_period_q <= '0;
			p2_vol_q    <= '0;
			w_period_q  <= '0;
			w_level_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_P1_DUTY:   p1_duty_q   <= cfg_data[1:0];
				REG_P1_PERIOD: p1_period_q <= cfg_data[PERIOD_W-1:0];
				REG_P1_VOLUME: p1_vol_q    <= cfg_data[3:0];
				REG_P2_DUTY:   p2_duty_q   <= cfg_data[1:0];
				REG_P2_PERIOD: p2_period_q <= cfg_data[PERIOD_W-1:0];
				REG_P2_VOLUME: p2_vol_q    <= cfg_data[3:0];
				REG_W_PERIOD:  w_period_q  <= cfg_data[PERIOD_W-1:0];
				REG_W_LEVEL:   w_level_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// (2048 - period) * SAMPLE_RATE
	logic [SPAN_W-1:0] span_p1, span_p2, span_w;
	assign span_p1 = SPAN_W'(PERIOD_SPAN) - {1'b0, p1_period_q};
	assign span_p2 = SPAN_W'(PERIOD_SPAN) - {1'b0, p2_period_q};
	assign span_w  = SPAN_W'(PERIOD_SPAN) - {1'b0, w_period_q};

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			d_p1_s1 <= DIV_W'(span_p1) * DIV_W'(SAMPLE_RATE);
			d_p2_s1 <= DIV_W'(span_p2) * DIV_W'(SAMPLE_RATE);
			d_w_s1  <= DIV_W'(span_w) * DIV_W'(SAMPLE_RATE);
		end
	end

	tsm_div u_div_p1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (d_p1_s1),
		.done    (p1_done),
		.quot    (p1_quot)
	);

	tsm_div u_div_p2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (d_p2_s1),
		.done    (p2_done),
		.quot    (p2_quot)
	);

	tsm_div u_div_w (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (d_w_s1),
		.done    (w_done),
		.quot    (w_quot)
	);

	// wave RAM: write from requests, read at the wave phase's byte
	logic [4:0] w_idx;
	logic [7:0] ram_rd_data;
	assign w_idx = w_phase_q[PHASE_BITS-1 -: 5];

	tsm_wave_ram u_wave_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ram_we),
		.wr_addr (wave_addr),
		.wr_data (wave_data),
		.rd_addr (w_idx[4:1]),
		.rd_data (ram_rd_data)
	);

	// channel evaluation
	logic [2:0]                 p1_eighth, p2_eighth;
	logic [MAG_W-1:0]           p1_amp, p2_amp, w_mag;
	logic [3:0]                 w_nib;
	logic [2:0]                 w_k;
	logic signed [SAMPLE_W-1:0] smp_a, smp_b, smp_c;

	always_comb begin
		p1_eighth = p1_phase_q[PHASE_BITS-1 -: 3];
		p2_eighth = p2_phase_q[PHASE_BITS-1 -: 3];
		p1_amp    = pulse_amp(p1_vol_q);
		p2_amp    = pulse_amp(p2_vol_q);
		smp_a = ({1'b0, p1_eighth} < duty_eighths(p1_duty_q)) ?
			signed'({1'b0, p1_amp}) : -signed'({1'b0, p1_amp});
		smp_b = ({1'b0, p2_eighth} < duty_eighths(p2_duty_q)) ?
			signed'({1'b0, p2_amp}) : -signed'({1'b0, p2_amp});
		// high nibble at even positions; |2n-15| = 2k+1
		w_nib = w_idx[0] ? ram_rd_data[3:0] : ram_rd_data[7:4];
		w_k   = w_nib[3] ? w_nib[2:0] : ~w_nib[2:0];
		w_mag = wave_mag(w_level_q, w_k);
		smp_c = w_nib[3] ? signed'({1'b0, w_mag}) : -signed'({1'b0, w_mag});
	end

	// mix / 3, truncated toward zero: divide the magnitude, restore the sign
	logic [SAMPLE_W-1:0]    sum_abs;
	logic [2*MAG_W-1:0]     div3_prod;
	logic [SAMPLE_W-1:0]    mix_mag;
	logic signed [SAMPLE_W-1:0] mix;

	always_comb begin
		sum_abs   = sum_q[SAMPLE_W-1] ? SAMPLE_W'(-sum_q) : SAMPLE_W'(sum_q);
		div3_prod = sum_abs[MAG_W-1:0] * MAG_W'(RECIP3);
		mix_mag   = SAMPLE_W'(div3_prod >> RECIP3_SHIFT);
		mix       = sum_q[SAMPLE_W-1] ? -signed'(mix_mag) : signed'(mix_mag);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			p1_phase_q  <= '0;
			p2_phase_q  <= '0;
			w_phase_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !fin_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && !req_type) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (p1_done) begin
						p1_phase_q <= p1_phase_q + p1_quot[PHASE_BITS-1:0];
						p2_phase_q <= p2_phase_q + p2_quot[PHASE_BITS-1:0];
						w_phase_q  <= w_phase_q + w_quot[PHASE_BITS:1];
						state_q    <= S_RD;
					end
				end
				S_RD:   state_q <= S_EVAL;
				S_EVAL: state_q <= S_FIN;
				S_FIN: begin
					if (fin_fire) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			sum_q <= smp_a + smp_b + smp_c;
		end
		if ((state_q == S_FIN) && (!out_valid_q || out_ready)) begin
			out_q <= mix;
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = out_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(p1_done == p2_done) && (p1_done == w_done))
		else $error("channel dividers out of step");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		p1_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result item raised outside the final state");

endmodule

>>> sv/tsm_div.sv
// restoring divider, one quotient bit per cycle: floor(2^DIV_STEPS / divisor)
module tsm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsm_pkg::DIV_W-1:0]   divisor,
	output logic                        done,
	output logic [tsm_pkg::QUOT_W-1:0]  quot
);
	import tsm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     div_q;
	logic [QUOT_W-1:0]    quot_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_diff;
	logic           q_bit;

	assign rem_sh   = {rem_q, 1'b0};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign q_bit    = (rem_sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DIV_W'(1);
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], q_bit};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with zero step count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !$past(start)) |-> rem_q < div_q)
		else $error("partial remainder not below divisor");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

endmodule

>>> sv/tsm_wave_ram.sv
// 16 x 8 wave RAM, cleared by reset, registered read
module tsm_wave_ram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [tsm_pkg::WAVE_AW-1:0]  wr_addr,
	input  logic [7:0]                   wr_data,
	input  logic [tsm_pkg::WAVE_AW-1:0]  rd_addr,
	output logic [7:0]                   rd_data
);
	import tsm_pkg::*;

	logic [7:0] mem_q [WAVE_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WAVE_DEPTH; i++) begin
				mem_q[i] <= '0;
			end
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
